// ----- src/infix_to_postfix_converter_assert.svh -----
// Assertion macros for the infix-to-postfix converter.
// Define ASSERT_OFF to compile the checks away.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ITP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ITP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ITP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ITP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/itp_pkg.sv -----
package itp_pkg;

	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	// precedence; "none" (-1) takes code 0 so that it is the smallest code
	localparam logic [1:0] PREC_NONE = 2'd0;
	localparam logic [1:0] PREC_ADD  = 2'd1;
	localparam logic [1:0] PREC_MUL  = 2'd2;
	localparam logic [1:0] PREC_POW  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORK,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		CLS_OPERAND,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OPER
	} char_class_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_CLOSE,
		ERR_OVERFLOW,
		ERR_OPEN
	} err_t;

	typedef enum logic [1:0] {
		EMIT_INPUT,
		EMIT_TOP,
		EMIT_CLOSING
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      push;
		logic      pop;
		logic      emit;
		emit_sel_t emit_sel;
		logic      flag;
		err_t      flag_code;
		logic      clear;
	} cmd_t;

	typedef struct packed {
		char_class_t cls;
		logic        end_seen;
		logic        empty;
		logic        full;
		logic        top_open;
		logic        top_prec_ge;
		logic        slot_free;
	} stat_t;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		p = PREC_NONE;
		if (c == CH_CARET)
			p = PREC_POW;
		else if (c == CH_STAR || c == CH_SLASH)
			p = PREC_MUL;
		else if (c == CH_PLUS || c == CH_MINUS)
			p = PREC_ADD;
		return p;
	endfunction

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t k;
		if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
		    (c >= 8'h30 && c <= 8'h39))
			k = CLS_OPERAND;
		else if (c == CH_OPEN)
			k = CLS_OPEN;
		else if (c == CH_CLOSE)
			k = CLS_CLOSE;
		else
			k = CLS_OPER;
		return k;
	endfunction

endpackage

// ----- src/itp_ctrl.sv -----
module itp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  itp_pkg::stat_t stat,
	output itp_pkg::cmd_t  cmd
);

	itp_pkg::state_t state_q, state_d;
	itp_pkg::state_t after_work;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= itp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.emit_sel  = itp_pkg::EMIT_INPUT;
		cmd.flag_code = itp_pkg::ERR_NONE;
		in_ready      = 1'b0;
		after_work    = stat.end_seen ? itp_pkg::ST_FLUSH : itp_pkg::ST_IDLE;
		case (state_q)
			itp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = itp_pkg::ST_WORK;
				end
			end
			itp_pkg::ST_WORK: begin
				case (stat.cls)
					itp_pkg::CLS_OPERAND: begin
						if (stat.slot_free) begin
							cmd.emit     = 1'b1;
							cmd.emit_sel = itp_pkg::EMIT_INPUT;
							state_d      = after_work;
						end
					end
					itp_pkg::CLS_OPEN: begin
						if (stat.full) begin
							cmd.flag      = 1'b1;
							cmd.flag_code = itp_pkg::ERR_OVERFLOW;
						end else begin
							cmd.push = 1'b1;
						end
						state_d = after_work;
					end
					itp_pkg::CLS_CLOSE: begin
						if (!stat.empty && !stat.top_open) begin
							if (stat.slot_free) begin
								cmd.emit     = 1'b1;
								cmd.emit_sel = itp_pkg::EMIT_TOP;
								cmd.pop      = 1'b1;
							end
						end else if (!stat.empty) begin
							cmd.pop = 1'b1;
							state_d = after_work;
						end else begin
							cmd.flag      = 1'b1;
							cmd.flag_code = itp_pkg::ERR_CLOSE;
							state_d       = after_work;
						end
					end
					default: begin
						if (!stat.empty && !stat.top_open && stat.top_prec_ge) begin
							if (stat.slot_free) begin
								cmd.emit     = 1'b1;
								cmd.emit_sel = itp_pkg::EMIT_TOP;
								cmd.pop      = 1'b1;
							end
						end else begin
							if (stat.full) begin
								cmd.flag      = 1'b1;
								cmd.flag_code = itp_pkg::ERR_OVERFLOW;
							end else begin
								cmd.push = 1'b1;
							end
							state_d = after_work;
						end
					end
				endcase
			end
			itp_pkg::ST_FLUSH: begin
				if (!stat.empty) begin
					if (stat.top_open) begin
						cmd.pop       = 1'b1;
						cmd.flag      = 1'b1;
						cmd.flag_code = itp_pkg::ERR_OPEN;
					end else if (stat.slot_free) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = itp_pkg::EMIT_TOP;
						cmd.pop      = 1'b1;
					end
				end else if (stat.slot_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = itp_pkg::EMIT_CLOSING;
					cmd.clear    = 1'b1;
					state_d      = itp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/itp_dp.sv -----
`include "infix_to_postfix_converter_assert.svh"

module itp_dp #(
	parameter int STACK_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     in_char,
	input  logic           in_end,
	input  itp_pkg::cmd_t  cmd,
	output itp_pkg::stat_t stat,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_has,
	output logic [7:0]     out_char,
	output logic           out_last,
	output itp_pkg::err_t  out_status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	logic [7:0]    stack_mem [STACK_DEPTH];
	logic [7:0]    ch_q;
	logic          end_q;
	logic [7:0]    top_q;
	logic [CW-1:0] cnt_q, cnt_d, cnt_dec;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	itp_pkg::err_t err_q, err_d;
	logic          out_valid_q, out_has_q, out_last_q;
	logic [7:0]    out_char_q;
	itp_pkg::err_t out_status_q;
	logic          slot_free;

	assign wr_en     = cmd.push && (cnt_q != DEPTH_C);
	assign wr_addr   = cnt_q[AW-1:0];
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.clear)
			cnt_d = '0;
		else if (wr_en)
			cnt_d = cnt_q + CW'(1);
		else if (cmd.pop)
			cnt_d = cnt_q - CW'(1);
		cnt_dec = cnt_d - CW'(1);
		rd_addr = (cnt_d == '0) ? '0 : cnt_dec[AW-1:0];
	end

	always_comb begin
		err_d = err_q;
		if (cmd.clear)
			err_d = itp_pkg::ERR_NONE;
		else if (cmd.flag && err_q == itp_pkg::ERR_NONE)
			err_d = cmd.flag_code;
	end

	// stack storage; top_q follows the entry below the next count (write-first)
	always_ff @(posedge clk) begin
		if (wr_en)
			stack_mem[wr_addr] <= ch_q;
		if (wr_en && wr_addr == rd_addr)
			top_q <= ch_q;
		else
			top_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= in_char;
			end_q <= in_end;
		end
		if (cmd.emit) begin
			out_has_q    <= (cmd.emit_sel != itp_pkg::EMIT_CLOSING);
			out_last_q   <= (cmd.emit_sel == itp_pkg::EMIT_CLOSING);
			out_status_q <= err_q;
			case (cmd.emit_sel)
				itp_pkg::EMIT_INPUT: out_char_q <= ch_q;
				itp_pkg::EMIT_TOP:   out_char_q <= top_q;
				default:             out_char_q <= 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			err_q       <= itp_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			err_q <= err_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.cls         = itp_pkg::classify(ch_q);
		stat.end_seen    = end_q;
		stat.empty       = (cnt_q == '0);
		stat.full        = (cnt_q == DEPTH_C);
		stat.top_open    = (top_q == itp_pkg::CH_OPEN);
		stat.top_prec_ge = (itp_pkg::prec_of(top_q) >= itp_pkg::prec_of(ch_q));
		stat.slot_free   = slot_free;
	end

	assign out_valid  = out_valid_q;
	assign out_has    = out_has_q;
	assign out_char   = out_char_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

	`ITP_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= DEPTH_C)
	`ITP_ASSERT_IMP(a_pop_nonempty, clk, arst_n, cmd.pop, cnt_q != '0)
	`ITP_ASSERT_IMP(a_emit_has_slot, clk, arst_n, cmd.emit, slot_free)
	`ITP_ASSERT_NXT(a_clear_resets, clk, arst_n, cmd.clear,
		cnt_q == '0 && err_q == itp_pkg::ERR_NONE && out_last_q)

endmodule

// ----- src/infix_to_postfix_converter.sv -----
// Infix-to-postfix converter (shunting-yard). Feed one ASCII character per
// item on the s_ side, s_tlast on the final character of an expression.
// Letters and digits come out at once; '(' and operators wait on an
// operator stack of STACK_DEPTH entries, operators leaving in postfix order
// (^ over * / over + -, everything else lowest, all left-associative).
// Each expression ends with one closing item: m_tuser (has_char) low,
// char 0, m_tlast high, and the final status. Status on every item is the
// first error seen so far in the expression: 0 ok, 1 unmatched ')',
// 2 stack overflow (the pushed character is dropped), 3 leftover '('.
// The block takes one item at a time. It accepts an item in the idle state;
// in the work state it pops stack entries one per cycle while the output
// has room, then pushes, emits or drops the item; after the final character
// a flush state pops the rest of the stack and sends the closing item.
// Results sit in an output register, so the next item is taken while the
// last result still waits; m_tready low stalls the work only when a new
// result has nowhere to go. No clearing pass after reset: stack entries are
// only read below the fill count.
`include "infix_to_postfix_converter_assert.svh"

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input characters
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_char
	input  logic        s_tlast,  // end_of_input
	// postfix results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] out_char, [9:8] status, [15:10] zero
	output logic        m_tuser,  // [0] has_char
	output logic        m_tlast   // end_of_output
);

	itp_pkg::cmd_t  cmd;
	itp_pkg::stat_t stat;
	logic [7:0]     res_char;
	itp_pkg::err_t  res_status;

	// sequencer: idle / per-character work / end-of-expression flush
	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// operator stack, error flag and output register
	itp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_char    (s_tdata),
		.in_end     (s_tlast),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_has    (m_tuser),
		.out_char   (res_char),
		.out_last   (m_tlast),
		.out_status (res_status)
	);

	assign m_tdata = {6'b0, res_status, res_char};

	// an item is only taken when the sequencer is not busy with the last one
	`ITP_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// the closing item never carries a character
	`ITP_ASSERT_IMP(a_closing_empty, clk, arst_n, m_tvalid && m_tlast,
		!m_tuser && m_tdata[7:0] == 8'h00)
	// a stalled result stays put
	`ITP_ASSERT_NXT(a_hold_stalled, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

endmodule

// ----- tb/sv/infix_to_postfix_converter_check.sv -----
module infix_to_postfix_converter_check #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_char
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // [7:0] out_char, [9:8] status, [15:10] zero
	input  logic        m_tuser,  // [0] has_char
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic          has_char;
		logic [7:0]    out_char;
		logic          end_of_output;
		itp_pkg::err_t status;
	} postfix_item_t;

	postfix_item_t expected_postfix[$];
	postfix_item_t want;
	logic [7:0]    op_stack[STACK_DEPTH];
	int unsigned   op_depth;
	itp_pkg::err_t first_err;
	int            mismatches = 0;

	assign fail_count = mismatches;

	function automatic int rank_of(logic [7:0] c);
		case (c)
			itp_pkg::CH_CARET:                    return 3;
			itp_pkg::CH_STAR, itp_pkg::CH_SLASH:  return 2;
			itp_pkg::CH_PLUS, itp_pkg::CH_MINUS:  return 1;
			default:                              return -1;
		endcase
	endfunction

	function automatic bit is_operand(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9");
	endfunction

	// only the first error of an expression sticks
	function automatic void note_err(itp_pkg::err_t e);
		if (first_err == itp_pkg::ERR_NONE)
			first_err = e;
	endfunction

	function automatic void emit(logic has, logic [7:0] ch, logic eo);
		expected_postfix.push_back('{has, ch, eo, first_err});
	endfunction

	function automatic void push_op(logic [7:0] c);
		if (op_depth >= STACK_DEPTH) begin
			note_err(itp_pkg::ERR_OVERFLOW);
		end else begin
			op_stack[op_depth] = c;
			op_depth++;
		end
	endfunction

	// shunting-yard step for one accepted character
	function automatic void convert_char(logic [7:0] c, logic last);
		logic [7:0] t;
		int         p;
		if (is_operand(c)) begin
			emit(1'b1, c, 1'b0);
		end else if (c == itp_pkg::CH_OPEN) begin
			push_op(c);
		end else if (c == itp_pkg::CH_CLOSE) begin
			while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::CH_OPEN) begin
				emit(1'b1, op_stack[op_depth-1], 1'b0);
				op_depth--;
			end
			if (op_depth > 0)
				op_depth--;
			else
				note_err(itp_pkg::ERR_CLOSE);
		end else begin
			p = rank_of(c);
			while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::CH_OPEN &&
			       rank_of(op_stack[op_depth-1]) >= p) begin
				emit(1'b1, op_stack[op_depth-1], 1'b0);
				op_depth--;
			end
			push_op(c);
		end
		if (last) begin
			while (op_depth > 0) begin
				t = op_stack[op_depth-1];
				op_depth--;
				if (t == itp_pkg::CH_OPEN)
					note_err(itp_pkg::ERR_OPEN);
				else
					emit(1'b1, t, 1'b0);
			end
			emit(1'b0, 8'h00, 1'b1);
			op_depth = 0;
			first_err = itp_pkg::ERR_NONE;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_postfix.delete();
			op_depth = 0;
			first_err = itp_pkg::ERR_NONE;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_postfix.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected item has=%0d ch=%02h eo=%0d st=%0d",
							$realtime, m_tuser, m_tdata[7:0], m_tlast, m_tdata[9:8]);
				end else begin
					want = expected_postfix.pop_front();
					if (m_tuser !== want.has_char || m_tdata[7:0] !== want.out_char ||
					    m_tlast !== want.end_of_output || m_tdata[9:8] !== want.status ||
					    m_tdata[15:10] !== 6'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d/%02h",
								$realtime,
								want.has_char, want.out_char, want.end_of_output,
								want.status, m_tuser, m_tdata[7:0], m_tlast,
								m_tdata[9:8], m_tdata[15:10]);
					end
				end
			end
			if (s_tvalid && s_tready)
				convert_char(s_tdata, s_tlast);
			pending <= expected_postfix.size();
		end
	end

endmodule

// ----- tb/sv/infix_to_postfix_converter_tb.sv -----
// Stimulus and verdict for the infix-to-postfix converter. The check module
// beside the block does all predicting and comparing; this top only feeds
// characters, stalls the result side, and decides pass/fail.
module infix_to_postfix_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         DEPTH        = 32;
	localparam int         RANDOM_ITEMS = 200;
	localparam int         CYCLE_LIMIT  = 2000000;  // far above the slowest legal run
	localparam int         DRAIN_CYCLES = 40;      // covers a full stack flush
	localparam logic [7:0] CH_SPACE     = 8'h20;   // a lowest-precedence operator

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;  // [7:0] in_char
	logic        s_tlast  = 1'b0;   // end_of_input
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] out_char, [9:8] status, [15:10] zero
	logic        m_tuser;           // [0] has_char
	logic        m_tlast;           // end_of_output

	int fail_count;
	int pending;

	// per-side idling switch; off gives back-to-back stretches
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;

	logic [7:0] expr_q[$];  // characters of the expression being built
	int         random_sent;
	int         kind;
	int         n;
	bit         first;

	infix_to_postfix_converter #(
		.STACK_DEPTH(DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	infix_to_postfix_converter_check #(
		.STACK_DEPTH(DEPTH)
	) postfix_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// One character per call. Valid is only lowered when a gap is drawn, so
	// back-to-back items keep it high without a drop inside one time step.
	// Called right after a rising edge; returns at the accepting edge.
	task automatic send_char(logic [7:0] c, logic last);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// whole expression, end_of_input on its final character
	task automatic send_expr();
		foreach (expr_q[i])
			send_char(expr_q[i], i == expr_q.size() - 1);
		expr_q.delete();
	endtask

	function automatic logic [7:0] any_operand();
		case ($urandom_range(0, 2))
			0:       return 8'("a" + $urandom_range(0, 25));
			1:       return 8'("A" + $urandom_range(0, 25));
			default: return 8'("0" + $urandom_range(0, 9));
		endcase
	endfunction

	// weighted toward the real operators; space stands in for "other"
	function automatic logic [7:0] any_operator();
		case ($urandom_range(0, 9))
			0, 1:    return itp_pkg::CH_CARET;
			2:       return itp_pkg::CH_STAR;
			3:       return itp_pkg::CH_SLASH;
			4, 5:    return itp_pkg::CH_PLUS;
			6, 7:    return itp_pkg::CH_MINUS;
			default: return CH_SPACE;
		endcase
	endfunction

	// well-formed infix: terms joined by operators, parenthesized sub-terms
	// up to four levels deep
	task automatic gen_expr(int lvl);
		int terms;
		terms = $urandom_range(1, 4);
		for (int i = 0; i < terms; i++) begin
			if (i > 0)
				expr_q.push_back(any_operator());
			if (lvl < 4 && $urandom_range(0, 3) == 0) begin
				expr_q.push_back(itp_pkg::CH_OPEN);
				gen_expr(lvl + 1);
				expr_q.push_back(itp_pkg::CH_CLOSE);
			end else begin
				expr_q.push_back(any_operand());
			end
		end
	endtask

	// Result side: a fresh stall length per item, zero while idling is off.
	initial begin : result_sink
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = snk_idle_on ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Hard stop if the block hangs or results go missing.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// all operators, both parentheses, the operand range ends but 'a'
		expr_q = '{"A", itp_pkg::CH_PLUS, "z", itp_pkg::CH_STAR, itp_pkg::CH_OPEN, "0",
			itp_pkg::CH_MINUS, "9", itp_pkg::CH_CLOSE, itp_pkg::CH_SLASH, "Z",
			itp_pkg::CH_CARET, "b"};
		send_expr();
		// unmatched close after an operand, ending on the ')'
		expr_q = '{"x", itp_pkg::CH_CLOSE};
		send_expr();
		// leftover '(' under an operand
		expr_q = '{itp_pkg::CH_OPEN, "a"};
		send_expr();
		// byte extremes and a space act as lowest-precedence operators; '^' on top
		expr_q = '{8'h00, 8'hFF, CH_SPACE, itp_pkg::CH_CARET};
		send_expr();
		// lone '(': closing item only, with the open error
		expr_q = '{itp_pkg::CH_OPEN};
		send_expr();

		// Hold off until every expected result is out.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// Random part. The first expression nests deep enough to overflow
		// the stack; the rest are mostly well-formed with some noise.
		random_sent = 0;
		first = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			src_idle_on = $urandom_range(0, 3) != 0;
			snk_idle_on = $urandom_range(0, 3) != 0;
			kind = first ? 0 : $urandom_range(0, 15);
			case (kind)
				0: begin
					// "(a+(b*(c^..." grows the stack two entries per level
					n = first ? 17 : $urandom_range(10, 18);
					repeat (n) begin
						expr_q.push_back(itp_pkg::CH_OPEN);
						expr_q.push_back(any_operand());
						expr_q.push_back(any_operator());
					end
					expr_q.push_back(any_operand());
					repeat ($urandom_range(0, n + 1)) expr_q.push_back(itp_pkg::CH_CLOSE);
				end
				1, 2: begin
					// raw bytes, any value
					repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(0, 255)));
				end
				3: begin
					// well-formed, then a stray parenthesis dropped in
					gen_expr(0);
					expr_q.insert($urandom_range(0, expr_q.size()),
						$urandom_range(0, 1) ? itp_pkg::CH_OPEN : itp_pkg::CH_CLOSE);
				end
				default: gen_expr(0);
			endcase
			random_sent += expr_q.size();
			send_expr();
			first = 1'b0;
		end
		s_tvalid <= 1'b0;

		// Drain, then give the block time to show anything extra.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/itp_pkg.sv
src/itp_ctrl.sv
src/itp_dp.sv
src/infix_to_postfix_converter.sv
tb/sv/infix_to_postfix_converter_check.sv
tb/sv/infix_to_postfix_converter_tb.sv
